// ----- rtl/cwam_pkg.sv -----
`default_nettype none

package cwam_pkg;

	localparam int TEMP_WINDOW_DEF = 15;
	localparam int HUM_WINDOW_DEF = 10;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEPTED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_ACCEPTED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_GOOD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_GOOD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_HUMIDITY = 3'd4;

	localparam logic [7:0] MAX_ACCEPTED_RST = 8'd72;
	localparam logic [7:0] MIN_ACCEPTED_RST = 8'd52;
	localparam logic [7:0] MAX_GOOD_RST = 8'd61;
	localparam logic [7:0] MIN_GOOD_RST = 8'd58;
	localparam logic [7:0] MIN_HUMIDITY_RST = 8'd30;

	localparam logic [1:0] COLOR_OFF = 2'd0;
	localparam logic [1:0] COLOR_ORANGE = 2'd1;
	localparam logic [1:0] COLOR_BLUE = 2'd2;
	localparam logic [1:0] COLOR_RED = 2'd3;

	localparam logic [5:0] TEMP_CAP = 6'd52;
	localparam logic [6:0] DRY_CAP = 7'd101;
	localparam logic [5:0] WARN_START = 6'd15;
	localparam logic [5:0] ALARM_AT = 6'd50;
	localparam logic [6:0] GOOD_START = 7'd5;
	localparam int WARN_EVERY = 5;
	localparam int GOOD_EVERY = 10;

	typedef struct packed {
		logic [6:0] temperature;
		logic [6:0] humidity;
		logic sensor_fault;
	} item_t;

	typedef struct packed {
		logic [1:0] led_color;
		logic temp_evaluated;
		logic hum_evaluated;
		logic hot_message;
		logic cold_message;
		logic perfect_message;
		logic dry_message;
		logic hot_alarm;
		logic cold_alarm;
		logic green_flash;
		logic pink_flash;
		logic fault_beep;
	} result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic logic is_mult5(input logic [6:0] v);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k <= 127 / WARN_EVERY; k++) begin
			if (v == 7'(WARN_EVERY * k)) hit = 1'b1;
		end
		return hit;
	endfunction

	function automatic logic is_mult10(input logic [6:0] v);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k <= 127 / GOOD_EVERY; k++) begin
			if (v == 7'(GOOD_EVERY * k)) hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/cwam_front.sv -----
`default_nettype none

module cwam_front
	import cwam_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [6:0] temperature,
	input  wire logic [6:0] humidity,
	input  wire logic sensor_fault,
	input  wire queue_status_t q_status,
	output logic push,
	output item_t push_item
);

	logic valid_s1;
	item_t item_s1;
	logic accept;

	assign in_stall = valid_s1 & q_status.full;
	assign accept = in_valid & ~in_stall;
	assign push = valid_s1 & ~q_status.full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// A fault beat carries no usable reading, so its samples are zeroed here.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.sensor_fault <= sensor_fault;
			item_s1.temperature <= sensor_fault ? 7'd0 : temperature;
			item_s1.humidity <= sensor_fault ? 7'd0 : humidity;
		end
	end

`ifndef SYNTH
	a_hold_until_pushed: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !push |=> valid_s1 && $stable(item_s1))
		else $error("front stage lost a beat");
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && q_status.full)
		else $error("front stalled without cause");
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted beat not held");
`endif

endmodule

`default_nettype wire

// ----- rtl/cwam_queue.sv -----
`default_nettype none

module cwam_queue
	import cwam_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire item_t push_item,
	input  wire logic pop,
	output item_t head,
	output queue_status_t status
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign status.full = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ----- rtl/cwam_back.sv -----
`default_nettype none

module cwam_back
	import cwam_pkg::*;
#(
	parameter int TEMP_WINDOW = TEMP_WINDOW_DEF,
	parameter int HUM_WINDOW = HUM_WINDOW_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire queue_status_t q_status,
	input  wire item_t head,
	output logic pop,
	output logic out_valid,
	input  wire logic out_stall,
	output result_t result
);

	localparam int TCW = $clog2(255 * TEMP_WINDOW + 1);
	localparam int TSW = TCW - 1;
	localparam int TFW = $clog2(TEMP_WINDOW + 1);
	localparam int HCW = $clog2(255 * HUM_WINDOW + 1);
	localparam int HSW = HCW - 1;
	localparam int HFW = $clog2(HUM_WINDOW + 1);
	localparam logic [TCW-1:0] TN = TCW'(TEMP_WINDOW);
	localparam logic [HCW-1:0] HN = HCW'(HUM_WINDOW);

	logic [7:0] max_acc_q, min_acc_q, max_good_q, min_good_q, min_hum_q;

	logic [6:0] temp_win_q [TEMP_WINDOW];
	logic [6:0] hum_win_q [HUM_WINDOW];
	logic [TSW-1:0] temp_sum_q;
	logic [HSW-1:0] hum_sum_q;
	logic [TFW-1:0] temp_fill_q;
	logic [HFW-1:0] hum_fill_q;
	logic [5:0] hot_count_q, cold_count_q, ideal_count_q;
	logic [6:0] dry_count_q;
	logic [1:0] held_color_q;
	logic out_valid_q;
	result_t res_q;

	logic temp_full, hum_full;
	logic [TCW-1:0] temp_s2;
	logic [HCW-1:0] hum_s2;
	logic hot_test, cold_test, ideal_test, dry_test;
	logic [5:0] hot_n, cold_n, ideal_n;
	logic [6:0] dry_n;
	logic [TSW-1:0] temp_sum_n;
	logic [HSW-1:0] hum_sum_n;
	logic [1:0] color_n;
	result_t res_n;

	assign pop = ~q_status.empty & (~out_valid_q | ~out_stall);
	assign out_valid = out_valid_q;
	assign result = res_q;

	assign temp_full = (temp_fill_q == TFW'(TEMP_WINDOW));
	assign hum_full = (hum_fill_q == HFW'(HUM_WINDOW));
	assign temp_s2 = {temp_sum_q, 1'b0};
	assign hum_s2 = {hum_sum_q, 1'b0};

	always_comb begin
		hot_test = temp_s2 > TCW'(max_acc_q) * TN;
		cold_test = temp_s2 < TCW'(min_acc_q) * TN;
		ideal_test = (temp_s2 <= TCW'(max_good_q) * TN) && (temp_s2 >= TCW'(min_good_q) * TN);
		dry_test = hum_s2 < HCW'(min_hum_q) * HN;

		hot_n = hot_test ? ((hot_count_q < TEMP_CAP) ? hot_count_q + 1'b1 : hot_count_q) : '0;
		cold_n = cold_test ? ((cold_count_q < TEMP_CAP) ? cold_count_q + 1'b1 : cold_count_q)
			: '0;
		ideal_n = ideal_test ? ((ideal_count_q < TEMP_CAP) ? ideal_count_q + 1'b1
			: ideal_count_q) : '0;
		dry_n = dry_test ? ((dry_count_q < DRY_CAP) ? dry_count_q + 1'b1 : dry_count_q) : '0;

		temp_sum_n = temp_full ? temp_sum_q + TSW'(head.temperature) - TSW'(temp_win_q[0])
			: temp_sum_q + TSW'(head.temperature);
		hum_sum_n = hum_full ? hum_sum_q + HSW'(head.humidity) - HSW'(hum_win_q[0])
			: hum_sum_q + HSW'(head.humidity);

		// Colour updates follow the hot, cold and ideal tests in that order; a fault beat forces red.
		color_n = held_color_q;
		if (temp_full) begin
			if (hot_test) begin
				if (hot_n >= WARN_START) color_n = COLOR_ORANGE;
			end else if (cold_count_q == '0) begin
				color_n = COLOR_OFF;
			end
			if (cold_test) begin
				if (cold_n >= WARN_START) color_n = COLOR_BLUE;
			end else if (hot_n == '0) begin
				color_n = COLOR_OFF;
			end
			if (!ideal_test && hot_n == '0 && cold_n == '0) color_n = COLOR_OFF;
		end
		if (head.sensor_fault) color_n = COLOR_RED;

		res_n = '0;
		res_n.led_color = color_n;
		if (head.sensor_fault) begin
			res_n.fault_beep = 1'b1;
		end else begin
			res_n.temp_evaluated = temp_full;
			res_n.hum_evaluated = hum_full;
			if (temp_full) begin
				res_n.hot_message = hot_test && hot_n >= WARN_START && is_mult5({1'b0, hot_n});
				res_n.hot_alarm = hot_test && hot_n >= ALARM_AT;
				res_n.cold_message = cold_test && cold_n >= WARN_START
					&& is_mult5({1'b0, cold_n});
				res_n.cold_alarm = cold_test && cold_n >= ALARM_AT;
				res_n.perfect_message = ideal_test && {1'b0, ideal_n} >= GOOD_START
					&& is_mult10({1'b0, ideal_n});
				res_n.green_flash = ideal_test && {1'b0, ideal_n} >= GOOD_START && !ideal_n[0];
			end
			if (hum_full) begin
				res_n.dry_message = dry_test && dry_n >= GOOD_START && is_mult10(dry_n);
				res_n.pink_flash = dry_test && dry_n >= GOOD_START && !dry_n[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_acc_q <= MAX_ACCEPTED_RST;
			min_acc_q <= MIN_ACCEPTED_RST;
			max_good_q <= MAX_GOOD_RST;
			min_good_q <= MIN_GOOD_RST;
			min_hum_q <= MIN_HUMIDITY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_ACCEPTED: max_acc_q <= cfg_data;
				CFG_MIN_ACCEPTED: min_acc_q <= cfg_data;
				CFG_MAX_GOOD: max_good_q <= cfg_data;
				CFG_MIN_GOOD: min_good_q <= cfg_data;
				CFG_MIN_HUMIDITY: min_hum_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_sum_q <= '0;
			hum_sum_q <= '0;
			temp_fill_q <= '0;
			hum_fill_q <= '0;
			hot_count_q <= '0;
			cold_count_q <= '0;
			ideal_count_q <= '0;
			dry_count_q <= '0;
			held_color_q <= COLOR_OFF;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				held_color_q <= color_n;
				if (!head.sensor_fault) begin
					temp_sum_q <= temp_sum_n;
					hum_sum_q <= hum_sum_n;
					if (!temp_full) begin
						temp_fill_q <= temp_fill_q + 1'b1;
					end else begin
						hot_count_q <= hot_n;
						cold_count_q <= cold_n;
						ideal_count_q <= ideal_n;
					end
					if (!hum_full) begin
						hum_fill_q <= hum_fill_q + 1'b1;
					end else begin
						dry_count_q <= dry_n;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_n;
			if (!head.sensor_fault) begin
				for (int i = 0; i < TEMP_WINDOW - 1; i++) temp_win_q[i] <= temp_win_q[i + 1];
				temp_win_q[TEMP_WINDOW - 1] <= head.temperature;
				for (int i = 0; i < HUM_WINDOW - 1; i++) hum_win_q[i] <= hum_win_q[i + 1];
				hum_win_q[HUM_WINDOW - 1] <= head.humidity;
			end
		end
	end

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		temp_fill_q <= TFW'(TEMP_WINDOW) && hum_fill_q <= HFW'(HUM_WINDOW))
		else $error("window fill beyond depth");
	a_count_caps: assert property (@(posedge clk) disable iff (!arst_n)
		hot_count_q <= TEMP_CAP && cold_count_q <= TEMP_CAP && ideal_count_q <= TEMP_CAP
		&& dry_count_q <= DRY_CAP)
		else $error("persistence counter beyond cap");
	a_fault_red: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.sensor_fault |=> held_color_q == COLOR_RED && res_q.fault_beep)
		else $error("fault beat did not set red");
	a_counts_idle_filling: assert property (@(posedge clk) disable iff (!arst_n)
		!temp_full |-> hot_count_q == '0 && cold_count_q == '0 && ideal_count_q == '0)
		else $error("counter moved before window full");
`endif

endmodule

`default_nettype wire

// ----- rtl/climate_window_alarm_monitor.sv -----
`default_nettype none

// Channel  Direction  Handshake               Payload
// in       into       in_valid / in_stall     temperature, humidity, sensor_fault
// out      out of     out_valid / out_stall   led_color and eleven one-bit flags
// cfg      into       cfg_we                  cfg_index, cfg_data
//
// One beat is taken per cycle while in_stall is low; it passes in turn through the front register,
// the queue and the result register, which shows it as a result beat.
// Running window sums keep each beat's work in the back part combinational, with no pass over the window.
// Reset clears fill counts, persistence counters, colour and handshake state at once.
// A stalled output fills the queue, then the front register; only then does the input stall.

module climate_window_alarm_monitor
	import cwam_pkg::*;
#(
	parameter int TEMP_WINDOW = TEMP_WINDOW_DEF,
	parameter int HUM_WINDOW = HUM_WINDOW_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [6:0] temperature,
	input  wire logic [6:0] humidity,
	input  wire logic sensor_fault,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [1:0] led_color,
	output logic temp_evaluated,
	output logic hum_evaluated,
	output logic hot_message,
	output logic cold_message,
	output logic perfect_message,
	output logic dry_message,
	output logic hot_alarm,
	output logic cold_alarm,
	output logic green_flash,
	output logic pink_flash,
	output logic fault_beep,
	input  wire logic cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	queue_status_t q_status;
	logic push, pop;
	item_t push_item, head;
	result_t result;

	cwam_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.temperature(temperature),
		.humidity(humidity),
		.sensor_fault(sensor_fault),
		.q_status(q_status),
		.push(push),
		.push_item(push_item)
	);

	cwam_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.pop(pop),
		.head(head),
		.status(q_status)
	);

	cwam_back #(
		.TEMP_WINDOW(TEMP_WINDOW),
		.HUM_WINDOW(HUM_WINDOW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.q_status(q_status),
		.head(head),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result(result)
	);

	assign led_color = result.led_color;
	assign temp_evaluated = result.temp_evaluated;
	assign hum_evaluated = result.hum_evaluated;
	assign hot_message = result.hot_message;
	assign cold_message = result.cold_message;
	assign perfect_message = result.perfect_message;
	assign dry_message = result.dry_message;
	assign hot_alarm = result.hot_alarm;
	assign cold_alarm = result.cold_alarm;
	assign green_flash = result.green_flash;
	assign pink_flash = result.pink_flash;
	assign fault_beep = result.fault_beep;

endmodule

`default_nettype wire
